// ===== rtl/tprd_pkg.sv =====
`default_nettype none
package tprd_pkg;

  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned COUNT_W  = 2;
  localparam int unsigned RUN_W    = 8;
  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [1:0] PHASE_HEADER  = 2'd0;
  localparam logic [1:0] PHASE_REPEAT  = 2'd1;
  localparam logic [1:0] PHASE_LITERAL = 2'd2;

  localparam logic [1:0] CFG_RUN_LENGTH_MODE = 2'd0;
  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [1:0] CFG_TOTAL_PIXELS    = 2'd2;

  localparam logic [2:0] BPP_24      = 3'd3;
  localparam logic [2:0] BPP_RESET   = 3'd4;
  localparam int unsigned HDR_REPEAT_BIT = 7;

  localparam logic [COUNT_W-1:0] COUNT_ONE = 2'd1;
  localparam logic [COUNT_W-1:0] COUNT_TWO = 2'd2;

  typedef struct packed {
    logic take;
    logic accept;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_start;
    logic run_final;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/tga_pixel_run_decoder_core.sv =====
`default_nettype none
// tga image-body pixel decoder
// in_*  : one body byte per request, in_tdata[7:0] = data_byte
// out_* : one result per request; out_tdata holds first_pixel [31:0],
//         second_pixel [63:32], pixel_count [65:64]; out_tlast is run_last,
//         out_tuser is image_done
// cfg_* : register writes, cfg_index 0 run_length_mode, 1 bytes_per_pixel,
//         2 total_pixels; cfg_ready is always high, write only while idle
// a result appears in the cycle after the byte that completes an uncompressed or literal pixel
// throughput: uncompressed and literal bytes go in at one per cycle while the output
//   is not stalled; the byte completing a repeat pixel is followed by its clipped run
//   as results of two pixels, the last of one or two, with input held, counted by the
//   run counter feeding the single output register
// bytes after the image's final pixel are taken and dropped
// reset clears the decode state, the pixel counter and the registers
//   (uncompressed, 4 bytes per pixel, zero pixels)
// a stall on out_tready holds the output register and, once it is full,
//   drops in_tready; nothing is lost
module tga_pixel_run_decoder_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // data_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // first_pixel, second_pixel, pixel_count, zero pad
  output logic [tprd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,  // run_last
  output logic                               out_tuser,  // image_done
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import tprd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;
  assign in_tready = cmd.take;

  tprd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tprd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ===== rtl/tprd_ctrl.sv =====
`default_nettype none
module tprd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  tprd_pkg::dp_status_t    sts,
  output tprd_pkg::ctrl_cmd_t     cmd
);
  import tprd_pkg::*;

  typedef enum logic {
    S_TAKE,
    S_RUN
  } state_t;

  state_t state_r;

  always_comb begin
    cmd.take   = (state_r == S_TAKE) && sts.out_free;
    cmd.accept = cmd.take && in_tvalid;
    cmd.step   = (state_r == S_RUN) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TAKE;
    end else begin
      case (state_r)
        S_TAKE: begin
          if (cmd.accept && sts.run_start) state_r <= S_RUN;
        end
        S_RUN: begin
          if (cmd.step && sts.run_final) state_r <= S_TAKE;
        end
        default: state_r <= S_TAKE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tprd_datapath.sv =====
`default_nettype none
module tprd_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  tprd_pkg::ctrl_cmd_t                cmd,
  output tprd_pkg::dp_status_t               sts,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output logic [tprd_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);
  import tprd_pkg::*;

  logic               rl_mode_r;
  logic [2:0]         bpp_r;
  logic [31:0]        total_r;

  logic [1:0]         phase_r, phase_nxt;
  logic [1:0]         byte_in_r, byte_in_nxt;
  logic [PIXEL_W-1:0] gather_r, gather_nxt;
  logic [RUN_W-1:0]   rem_r, rem_nxt;
  logic [31:0]        emitted_r, emitted_nxt;
  logic [RUN_W-1:0]   run_left_r, run_left_nxt;

  logic               out_valid_r;
  logic [PIXEL_W-1:0] first_r, second_r;
  logic [COUNT_W-1:0] count_r;
  logic               last_r, done_r;

  logic               size3, complete, done, live;
  logic [PIXEL_W-1:0] shifted, gather_sum, gather_done, swapped;
  logic [31:0]        left;
  logic [RUN_W-1:0]   want, run_len;
  logic               emit_one;
  logic [PIXEL_W-1:0] emit_pix;
  logic [COUNT_W-1:0] emit_c;
  logic [31:0]        emitted_sum;
  logic               load;

  // pixel byte assembly, image end and clipped run length
  always_comb begin
    size3       = (bpp_r == BPP_24);
    complete    = size3 ? (byte_in_r >= 2'd2) : (byte_in_r == 2'd3);
    shifted     = {24'd0, in_byte} << {byte_in_r, 3'b000};
    gather_sum  = (byte_in_r == 2'd0) ? {24'd0, in_byte} : (gather_r | shifted);
    gather_done = size3 ? {8'd0, gather_sum[23:0]} : gather_sum;
    swapped     = {gather_done[31:24], gather_done[7:0], gather_done[15:8],
                   gather_done[23:16]};
    done        = (emitted_r >= total_r);
    live        = cmd.accept && !done;
    left        = total_r - emitted_r;
    want        = {1'b0, rem_r[6:0]} + 8'd1;
    run_len     = (left < 32'(want)) ? left[RUN_W-1:0] : want;
  end

  always_comb begin
    phase_nxt    = phase_r;
    byte_in_nxt  = byte_in_r;
    gather_nxt   = gather_r;
    rem_nxt      = rem_r;
    run_left_nxt = run_left_r;
    emit_one     = 1'b0;
    emit_pix     = gather_done;
    sts.run_start = 1'b0;
    sts.out_free  = !out_valid_r || out_tready;
    sts.run_final = (run_left_r <= 8'd2);
    if (live) begin
      if (!rl_mode_r) begin
        byte_in_nxt = complete ? 2'd0 : byte_in_r + 2'd1;
        gather_nxt  = complete ? gather_done : gather_sum;
        emit_one    = complete;
        emit_pix    = swapped;
      end else begin
        case (phase_r)
          PHASE_REPEAT: begin
            byte_in_nxt = complete ? 2'd0 : byte_in_r + 2'd1;
            gather_nxt  = complete ? gather_done : gather_sum;
            if (complete) begin
              phase_nxt     = PHASE_HEADER;
              run_left_nxt  = run_len;
              sts.run_start = 1'b1;
            end
          end
          PHASE_LITERAL: begin
            byte_in_nxt = complete ? 2'd0 : byte_in_r + 2'd1;
            gather_nxt  = complete ? gather_done : gather_sum;
            emit_one    = complete;
            if (complete) begin
              if (rem_r == '0) phase_nxt = PHASE_HEADER;
              else rem_nxt = rem_r - 8'd1;
            end
          end
          default: begin
            byte_in_nxt = 2'd0;
            if (in_byte[HDR_REPEAT_BIT]) begin
              rem_nxt   = {1'b0, in_byte[6:0]};
              phase_nxt = PHASE_REPEAT;
            end else begin
              rem_nxt   = in_byte;
              phase_nxt = PHASE_LITERAL;
            end
          end
        endcase
      end
    end
    if (cmd.step) run_left_nxt = run_left_r - 8'(emit_c);
  end

  // result forming, single pixel or one or two pixels of a repeat run
  always_comb begin
    emit_c = (cmd.step && run_left_r >= 8'd2) ? COUNT_TWO : COUNT_ONE;
    emitted_sum = emitted_r + 32'(emit_c);
    load = emit_one || cmd.step;
    emitted_nxt = load ? emitted_sum : emitted_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl_mode_r   <= 1'b0;
      bpp_r       <= BPP_RESET;
      total_r     <= '0;
      phase_r     <= PHASE_HEADER;
      byte_in_r   <= '0;
      gather_r    <= '0;
      rem_r       <= '0;
      emitted_r   <= '0;
      run_left_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RUN_LENGTH_MODE: rl_mode_r <= cfg_data[0];
          CFG_BYTES_PER_PIXEL: bpp_r     <= cfg_data[2:0];
          CFG_TOTAL_PIXELS:    total_r   <= cfg_data;
          default: ;
        endcase
      end
      phase_r     <= phase_nxt;
      byte_in_r   <= byte_in_nxt;
      gather_r    <= gather_nxt;
      rem_r       <= rem_nxt;
      emitted_r   <= emitted_nxt;
      run_left_r  <= run_left_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_r  <= cmd.step ? gather_r : emit_pix;
      second_r <= (emit_c == COUNT_TWO) ? gather_r : '0;
      count_r  <= emit_c;
      last_r   <= cmd.step ? (run_left_r == 8'(emit_c)) : 1'b1;
      done_r   <= (emitted_sum == total_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, count_r, second_r, first_r};
  assign out_tlast  = last_r;
  assign out_tuser  = done_r;

endmodule
`default_nettype wire

// ===== rtl/tprd_checker.sv =====
`default_nettype none
module tprd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [tprd_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tlast,
  input wire logic                          out_tuser
);
  import tprd_pkg::*;

  // stalled request stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped under stall");

  // count is one or two
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[65:64] == COUNT_ONE || out_tdata[65:64] == COUNT_TWO))
    else $error("bad pixel count");

  // single pixel results carry a zero second pixel
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] == COUNT_ONE |-> out_tdata[63:32] == '0)
    else $error("second pixel not cleared");

  // image end is always the last result of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("image done without run end");

endmodule

bind tga_pixel_run_decoder_core tprd_checker u_tprd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== dv/tb_tga_pixel_run_decoder_core.sv =====
`default_nettype none

typedef struct packed {
  logic [tprd_pkg::PIXEL_W-1:0] first_pixel;
  logic [tprd_pkg::PIXEL_W-1:0] second_pixel;
  logic [tprd_pkg::COUNT_W-1:0] pixel_count;
  logic                         run_last;
  logic                         image_done;
} pixel_result_t;

class tga_pixel_predictor;
  logic        rle_mode;
  logic [2:0]  pix_bytes;
  logic [31:0] pix_total;
  logic [1:0]  phase;
  logic [1:0]  byte_idx;
  logic [31:0] gather_word;
  logic [7:0]  left_in_packet;
  logic [31:0] pix_sent;
  pixel_result_t due[$];
  int errors;
  int checked;
  int live_bytes;

  function new();
    rle_mode = 1'b0;
    pix_bytes = tprd_pkg::BPP_RESET;
    pix_total = '0;
    phase = tprd_pkg::PHASE_HEADER;
    byte_idx = '0;
    gather_word = '0;
    left_in_packet = '0;
    pix_sent = '0;
    errors = 0;
    checked = 0;
    live_bytes = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      tprd_pkg::CFG_RUN_LENGTH_MODE: rle_mode = val[0];
      tprd_pkg::CFG_BYTES_PER_PIXEL: pix_bytes = val[2:0];
      tprd_pkg::CFG_TOTAL_PIXELS:    pix_total = val;
      default: ;
    endcase
  endfunction

  function int pixel_len();
    return (pix_bytes == tprd_pkg::BPP_24) ? 3 : 4;
  endfunction

  // adds one byte to the pixel being assembled, true when it is complete
  function bit gather(logic [7:0] b);
    if (byte_idx == 2'd0) gather_word = {24'd0, b};
    else gather_word = gather_word | ({24'd0, b} << (8 * byte_idx));
    if (int'(byte_idx) + 1 >= pixel_len()) begin
      byte_idx = 2'd0;
      if (pixel_len() == 3) gather_word[31:24] = 8'd0;
      return 1'b1;
    end
    byte_idx = byte_idx + 2'd1;
    return 1'b0;
  endfunction

  // n copies of one pixel, paired up, clipped at the image total
  function void queue_copies(logic [31:0] pix, logic [31:0] n);
    logic [31:0] room;
    pixel_result_t r;
    room = pix_total - pix_sent;
    if (n > room) n = room;
    while (n > 0) begin
      r.pixel_count = (n >= 2) ? tprd_pkg::COUNT_TWO : tprd_pkg::COUNT_ONE;
      n = n - r.pixel_count;
      pix_sent = pix_sent + r.pixel_count;
      r.first_pixel = pix;
      r.second_pixel = (r.pixel_count == tprd_pkg::COUNT_TWO) ? pix : '0;
      r.run_last = (n == 0);
      r.image_done = (pix_sent == pix_total);
      due.push_back(r);
    end
  endfunction

  function void take_body_byte(logic [7:0] b);
    if (pix_sent >= pix_total) return;
    live_bytes++;
    if (!rle_mode) begin
      if (gather(b))
        queue_copies({gather_word[31:24], gather_word[7:0], gather_word[15:8],
                      gather_word[23:16]}, 32'd1);
      return;
    end
    case (phase)
      tprd_pkg::PHASE_REPEAT: begin
        if (gather(b)) begin
          phase = tprd_pkg::PHASE_HEADER;
          queue_copies(gather_word, {25'd0, left_in_packet[6:0]} + 32'd1);
        end
      end
      tprd_pkg::PHASE_LITERAL: begin
        if (gather(b)) begin
          if (left_in_packet == 8'd0) phase = tprd_pkg::PHASE_HEADER;
          else left_in_packet = left_in_packet - 8'd1;
          queue_copies(gather_word, 32'd1);
        end
      end
      default: begin
        byte_idx = 2'd0;
        if (b[tprd_pkg::HDR_REPEAT_BIT]) begin
          left_in_packet = {1'b0, b[6:0]};
          phase = tprd_pkg::PHASE_REPEAT;
        end else begin
          left_in_packet = b;
          phase = tprd_pkg::PHASE_LITERAL;
        end
      end
    endcase
  endfunction

  function void match_result(logic [tprd_pkg::OUT_DATA_W-1:0] data, logic last,
                             logic user);
    pixel_result_t want;
    logic [tprd_pkg::PIXEL_W-1:0] got_first;
    logic [tprd_pkg::PIXEL_W-1:0] got_second;
    logic [tprd_pkg::COUNT_W-1:0] got_count;
    if (due.size() == 0) begin
      $error("result with no pixels pending: tdata %h", data);
      errors++;
      return;
    end
    want = due.pop_front();
    checked++;
    got_first = data[tprd_pkg::PIXEL_W-1:0];
    got_second = data[2*tprd_pkg::PIXEL_W-1:tprd_pkg::PIXEL_W];
    got_count = data[2*tprd_pkg::PIXEL_W+tprd_pkg::COUNT_W-1:2*tprd_pkg::PIXEL_W];
    if (got_first !== want.first_pixel) begin
      $error("first_pixel expected %h got %h", want.first_pixel, got_first);
      errors++;
    end
    if (got_second !== want.second_pixel) begin
      $error("second_pixel expected %h got %h", want.second_pixel, got_second);
      errors++;
    end
    if (got_count !== want.pixel_count) begin
      $error("pixel_count expected %0d got %0d", want.pixel_count, got_count);
      errors++;
    end
    if (last !== want.run_last) begin
      $error("run_last expected %b got %b", want.run_last, last);
      errors++;
    end
    if (user !== want.image_done) begin
      $error("image_done expected %b got %b", want.image_done, user);
      errors++;
    end
  endfunction
endclass

module tb_tga_pixel_run_decoder_core;
  import tprd_pkg::*;

  localparam int          CYCLE_LIMIT     = 1_000_000;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          RANDOM_BYTES    = 180;
  localparam int          PRESSURE_CYCLES = 300;
  localparam logic [2:0]  BPP_ODD         = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [31:0]           cfg_data = '0;

  tga_pixel_predictor pred;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;

  tga_pixel_run_decoder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check every accepted request, then pick next ready
  always @(posedge clk) begin
    if (out_tvalid && out_tready) pred.match_result(out_tdata, out_tlast, out_tuser);
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = PRESSURE_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred.take_body_byte(b);
  endtask

  task automatic send_all(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pred.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pred.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // packets with random content in run-length mode, plain bytes otherwise
  task automatic send_packets(input int budget);
    int sent;
    int reps;
    int nbytes;
    logic [7:0] hdr;
    sent = 0;
    while (sent < budget) begin
      if (!pred.rle_mode || $urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        case ($urandom_range(0, 9))
          8:       reps = $urandom_range(8, 40);
          9:       reps = 127;
          default: reps = $urandom_range(0, 7);
        endcase
        hdr[HDR_REPEAT_BIT] = 1'($urandom_range(0, 1));
        hdr[6:0] = reps[6:0];
        send_byte(hdr);
        sent++;
        nbytes = (hdr[HDR_REPEAT_BIT] ? 1 : reps + 1) * pred.pixel_len();
        for (int k = 0; k < nbytes && sent < budget; k++) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [7:0] body[$];
    logic [2:0] bpp;
    int base;
    int pick;
    pred = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 20;
    recv_idle = 20;
    // zero pixel total: everything dropped
    body = '{8'h00, 8'hff};
    send_all(body);
    wait_idle();
    write_reg(CFG_TOTAL_PIXELS, 32'hffff_ffff);
    write_reg(CFG_BYTES_PER_PIXEL, {29'd0, BPP_24});
    body = '{8'h00, 8'hff, 8'h5a, 8'hff, 8'h00, 8'ha5};
    send_all(body);
    wait_idle();
    write_reg(CFG_BYTES_PER_PIXEL, {29'd0, BPP_ODD});
    body = '{8'h12, 8'h34, 8'h56, 8'h78};
    send_all(body);
    wait_idle();
    write_reg(CFG_RUN_LENGTH_MODE, 32'd1);
    write_reg(CFG_BYTES_PER_PIXEL, {29'd0, BPP_24});
    body = '{8'hff, 8'ha1, 8'hb2, 8'hc3, 8'h00, 8'h0f, 8'hf0, 8'h81};
    send_all(body);
    wait_idle();
    // repeat run clipped at the image end, then dropped bytes
    write_reg(CFG_TOTAL_PIXELS, pred.pix_sent + 32'd3);
    body = '{8'h85, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
    send_all(body);
    wait_idle();

    base = pred.live_bytes;
    while (pred.live_bytes - base < RANDOM_BYTES) begin
      if (pred.live_bytes - base < RANDOM_BYTES / 3) begin
        send_idle = 32;
        recv_idle = 88;
      end else if (pred.live_bytes - base < 2 * RANDOM_BYTES / 3) begin
        send_idle = 88;
        recv_idle = 32;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      wait_idle();
      write_reg(CFG_RUN_LENGTH_MODE, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
      pick = $urandom_range(0, 9);
      if (pick < 4) bpp = BPP_24;
      else if (pick < 8) bpp = BPP_RESET;
      else bpp = 3'($urandom_range(0, 7));
      write_reg(CFG_BYTES_PER_PIXEL, {29'd0, bpp});
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_TOTAL_PIXELS, pred.pix_sent + $urandom_range(1, 12));
      else
        write_reg(CFG_TOTAL_PIXELS, pred.pix_sent + $urandom_range(300, 3000));
      send_packets($urandom_range(12, 40));
    end

    // long receiver stall while bytes keep coming
    wait_idle();
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_RUN_LENGTH_MODE, 32'd0);
    write_reg(CFG_BYTES_PER_PIXEL, {29'd0, BPP_RESET});
    write_reg(CFG_TOTAL_PIXELS, pred.pix_sent + 32'd1000);
    hold_asked = hold_asked + 1;
    send_packets(40);
    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    if (pred.due.size() != 0) begin
      $error("%0d results never arrived", pred.due.size());
      pred.errors++;
    end
    $display("%0d body bytes decoded into %0d results (%0d pixels)",
             pred.live_bytes, pred.checked, pred.pix_sent);
    $display("both modes, all pixel sizes, clipped runs, idle mixes and a long output stall");
    if (pred.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
